FILE: rtl/core/dcc_pkg.sv
package dcc_pkg;

   localparam int THRESH_BITS = 10;
   localparam int DWELL_BITS  = 16;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [THRESH_BITS-1:0] THRESH_RESET = 10'd10;
   localparam logic [DWELL_BITS-1:0]  DWELL_RESET  = 16'd1200;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MOTION_THRESHOLD = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DWELL_TICKS      = 1'b1;

   typedef enum logic [2:0] {
      OP_MOTION   = 3'd0,
      OP_BUTTON   = 3'd1,
      OP_TICK     = 3'd2,
      OP_SET_TYPE = 3'd3,
      OP_REARM    = 3'd4
   } opcode_type;

   typedef enum logic [2:0] {
      CT_PRIMARY   = 3'd0,
      CT_MIDDLE    = 3'd1,
      CT_SECONDARY = 3'd2,
      CT_DOUBLE    = 3'd3,
      CT_DRAG      = 3'd4
   } press_kind_type;

   typedef enum logic [1:0] {
      ACT_NONE    = 2'd0,
      ACT_CLICK   = 2'd1,
      ACT_PRESS   = 2'd2,
      ACT_RELEASE = 2'd3
   } action_type;

   localparam logic [1:0] BTN_NONE   = 2'd0;
   localparam logic [1:0] BTN_LEFT   = 2'd1;
   localparam logic [1:0] BTN_MIDDLE = 2'd2;
   localparam logic [1:0] BTN_RIGHT  = 2'd3;

   typedef struct packed {
      action_type     action;
      logic [1:0]     button;
      press_kind_type press_kind;
      logic           running;
      logic           twice;
   } result_type;

endpackage

FILE: rtl/core/dcc_engine.sv
module dcc_engine #(
   parameter int COORD_BITS = 16,
   parameter int TIMER_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               step,
   input  logic [2:0]                         opcode,
   input  logic signed [COORD_BITS-1:0]       pos_x,
   input  logic signed [COORD_BITS-1:0]       pos_y,
   input  logic [2:0]                         new_click_type,
   input  logic [dcc_pkg::THRESH_BITS-1:0]    motion_threshold,
   input  logic [dcc_pkg::DWELL_BITS-1:0]     dwell_ticks,
   output dcc_pkg::result_type                result
);
   import dcc_pkg::*;

   localparam int MW = (COORD_BITS + 1 > THRESH_BITS + 1) ? COORD_BITS + 1 : THRESH_BITS + 1;
   localparam int TW = (TIMER_BITS > DWELL_BITS) ? TIMER_BITS : DWELL_BITS;
   localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

   logic signed [COORD_BITS-1:0] rest_x_ff, rest_x_in;
   logic signed [COORD_BITS-1:0] rest_y_ff, rest_y_in;
   logic                         known_ff, known_in;
   press_kind_type               type_ff, type_in;
   logic                         drag_ff, drag_in;
   logic                         timer_ff, timer_in;
   logic [TIMER_BITS-1:0]        elapsed_ff, elapsed_in;

   logic signed [MW-1:0] dx, dy;
   logic [MW-1:0]        adx, ady, thr;
   logic                 moved;
   logic [TW-1:0]        target, dwell_ext, tmax_ext;
   logic [TIMER_BITS-1:0] elapsed_inc;
   logic                 expire;
   action_type           act;
   logic [1:0]           btn;
   logic                 twice;

   always_comb begin
      dx  = MW'(pos_x) - MW'(rest_x_ff);
      dy  = MW'(pos_y) - MW'(rest_y_ff);
      adx = dx[MW-1] ? $unsigned(-dx) : $unsigned(dx);
      ady = dy[MW-1] ? $unsigned(-dy) : $unsigned(dy);
      thr = MW'(motion_threshold);
      moved = (adx > thr) || (ady > thr);

      dwell_ext = TW'(dwell_ticks);
      tmax_ext  = TW'(TMAX);
      target    = (dwell_ticks == '0) ? TW'(1) : dwell_ext;
      if (target > tmax_ext) begin
         target = tmax_ext;
      end
      elapsed_inc = (elapsed_ff == TMAX) ? elapsed_ff : elapsed_ff + TIMER_BITS'(1);
      expire      = TW'(elapsed_inc) >= target;

      rest_x_in  = rest_x_ff;
      rest_y_in  = rest_y_ff;
      known_in   = known_ff;
      type_in    = type_ff;
      drag_in    = drag_ff;
      timer_in   = timer_ff;
      elapsed_in = elapsed_ff;
      act        = ACT_NONE;
      btn        = BTN_NONE;
      twice      = 1'b0;

      unique case (opcode)
         OP_MOTION: begin
            if (!known_ff) begin
               rest_x_in = pos_x;
               rest_y_in = pos_y;
               known_in  = 1'b1;
            end else if (moved) begin
               rest_x_in  = pos_x;
               rest_y_in  = pos_y;
               timer_in   = 1'b1;
               elapsed_in = '0;
            end
         end
         OP_BUTTON: begin
            if (timer_ff) begin
               timer_in   = 1'b0;
               elapsed_in = '0;
               drag_in    = 1'b0;
               type_in    = CT_PRIMARY;
            end
         end
         OP_TICK: begin
            if (timer_ff) begin
               elapsed_in = elapsed_inc;
               if (expire) begin
                  timer_in   = 1'b0;
                  elapsed_in = '0;
                  if (drag_ff) begin
                     drag_in = 1'b0;
                     act     = ACT_RELEASE;
                     btn     = BTN_LEFT;
                     type_in = CT_PRIMARY;
                  end else begin
                     unique case (type_ff)
                        CT_PRIMARY: begin
                           act = ACT_CLICK;
                           btn = BTN_LEFT;
                        end
                        CT_MIDDLE: begin
                           act     = ACT_CLICK;
                           btn     = BTN_MIDDLE;
                           type_in = CT_PRIMARY;
                        end
                        CT_SECONDARY: begin
                           act     = ACT_CLICK;
                           btn     = BTN_RIGHT;
                           type_in = CT_PRIMARY;
                        end
                        CT_DOUBLE: begin
                           act     = ACT_CLICK;
                           btn     = BTN_LEFT;
                           twice   = 1'b1;
                           type_in = CT_PRIMARY;
                        end
                        CT_DRAG: begin
                           act     = ACT_PRESS;
                           btn     = BTN_LEFT;
                           drag_in = 1'b1;
                        end
                        default: begin
                           act = ACT_NONE;
                        end
                     endcase
                  end
               end
            end
         end
         OP_SET_TYPE: begin
            if (new_click_type <= CT_DRAG) begin
               type_in = press_kind_type'(new_click_type);
            end
         end
         OP_REARM: begin
            known_in = 1'b0;
         end
         default: begin
            known_in = known_ff;
         end
      endcase

      result.action     = act;
      result.button     = btn;
      result.press_kind = type_in;
      result.running    = timer_in;
      result.twice      = twice;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         known_ff   <= 1'b0;
         type_ff    <= CT_PRIMARY;
         drag_ff    <= 1'b0;
         timer_ff   <= 1'b0;
         elapsed_ff <= '0;
      end else if (step) begin
         known_ff   <= known_in;
         type_ff    <= type_in;
         drag_ff    <= drag_in;
         timer_ff   <= timer_in;
         elapsed_ff <= elapsed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rest_x_ff <= rest_x_in;
         rest_y_ff <= rest_y_in;
      end
   end

endmodule

FILE: rtl/core/dwell_click_controller.sv
// An accepted item waits in the input register until the result register is free; it is
// then processed, which updates the state and puts its first result in the result register.
// Throughput: one item per cycle while rsp_stall is low, set by the single state update
// between input and result registers; a double click holds input for its second result.
// Reset clears the position flag, timer, drag and click type (primary), sets
// motion_threshold to 10 and dwell_ticks to 1200, and empties both registers.
module dwell_click_controller #(
   parameter int COORD_BITS = 16,
   parameter int TIMER_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [2:0]                           req_opcode,
   input  logic signed [COORD_BITS-1:0]         req_pos_x,
   input  logic signed [COORD_BITS-1:0]         req_pos_y,
   input  logic [2:0]                           req_new_click_type,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [1:0]                           rsp_action,
   output logic [1:0]                           rsp_button_number,
   output logic [2:0]                           rsp_current_type,
   output logic                                 rsp_dwell_running,
   output logic                                 rsp_last_result,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [dcc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [dcc_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   import dcc_pkg::*;

   logic [THRESH_BITS-1:0]       threshold_ff;
   logic [DWELL_BITS-1:0]        dwell_ff;

   logic                         in_valid_ff;
   logic [2:0]                   in_opcode_ff;
   logic signed [COORD_BITS-1:0] in_pos_x_ff;
   logic signed [COORD_BITS-1:0] in_pos_y_ff;
   logic [2:0]                   in_type_ff;

   logic                         out_valid_ff;
   logic                         out_second_ff;
   logic                         out_last_ff;
   result_type                   out_ff;

   result_type                   result;
   logic                         out_take;
   logic                         out_free;
   logic                         process;
   logic                         req_take;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESH_RESET;
         dwell_ff     <= DWELL_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MOTION_THRESHOLD: threshold_ff <= csr_data[THRESH_BITS-1:0];
            CSR_DWELL_TICKS:      dwell_ff     <= csr_data[DWELL_BITS-1:0];
            default:              dwell_ff     <= dwell_ff;
         endcase
      end
   end

   assign out_take  = out_valid_ff && !rsp_stall;
   assign out_free  = !out_valid_ff || (out_take && !out_second_ff);
   assign process   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !process;
   assign req_take  = req_valid && !req_stall;

   dcc_engine #(
      .COORD_BITS (COORD_BITS),
      .TIMER_BITS (TIMER_BITS)
   ) u_engine (
      .clock            (clock),
      .reset            (reset),
      .step             (process),
      .opcode           (in_opcode_ff),
      .pos_x            (in_pos_x_ff),
      .pos_y            (in_pos_y_ff),
      .new_click_type   (in_type_ff),
      .motion_threshold (threshold_ff),
      .dwell_ticks      (dwell_ff),
      .result           (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (process) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_opcode_ff <= req_opcode;
         in_pos_x_ff  <= req_pos_x;
         in_pos_y_ff  <= req_pos_y;
         in_type_ff   <= req_new_click_type;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         out_second_ff <= 1'b0;
      end else if (process) begin
         out_valid_ff  <= 1'b1;
         out_second_ff <= result.twice;
      end else if (out_take && out_second_ff) begin
         out_second_ff <= 1'b0;
      end else if (out_take) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (process) begin
         out_ff      <= result;
         out_last_ff <= !result.twice;
      end else if (out_take && out_second_ff) begin
         out_last_ff <= 1'b1;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_action        = out_ff.action;
   assign rsp_button_number = out_ff.button;
   assign rsp_current_type  = out_ff.press_kind;
   assign rsp_dwell_running = out_ff.running;
   assign rsp_last_result   = out_last_ff;

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import dcc_pkg::*;

   typedef struct packed {
      action_type     action;
      logic [1:0]     button;
      press_kind_type press_kind;
      logic           running;
      logic           last;
   } click_result_type;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [2:0]                req_opcode;
   logic signed [15:0]        req_pos_x;
   logic signed [15:0]        req_pos_y;
   logic [2:0]                req_new_click_type;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [1:0]                rsp_action;
   logic [1:0]                rsp_button_number;
   logic [2:0]                rsp_current_type;
   logic                      rsp_dwell_running;
   logic                      rsp_last_result;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_data;

   logic [THRESH_BITS-1:0] threshold = THRESH_RESET;
   logic [DWELL_BITS-1:0]  dwell_target = DWELL_RESET;
   logic signed [15:0]     rest_x = '0;
   logic signed [15:0]     rest_y = '0;
   logic                   position_known = 1'b0;
   logic                   drag_active = 1'b0;
   logic                   timer_active = 1'b0;
   press_kind_type         selected = CT_PRIMARY;
   logic [15:0]            elapsed = '0;

   click_result_type expected_clicks[$];
   int errors = 0;
   int items_sent = 0;
   int results_seen = 0;
   int events_seen = 0;
   int config_sets = 0;
   int stall_left = 0;
   logic no_idle = 1'b0;

   dwell_click_controller #(.COORD_BITS(16), .TIMER_BITS(16)) dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic predict_step(input logic [2:0] op, input logic signed [15:0] x,
                               input logic signed [15:0] y, input logic [2:0] kind);
      action_type       act [2];
      logic [1:0]       btn [2];
      int               n;
      int               dx;
      int               dy;
      logic [15:0]      target;
      click_result_type r;
      act[0] = ACT_NONE;
      act[1] = ACT_NONE;
      btn[0] = BTN_NONE;
      btn[1] = BTN_NONE;
      n = 1;
      case (op)
         OP_MOTION: begin
            dx = int'(rest_x) - int'(x);
            dy = int'(rest_y) - int'(y);
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            if (!position_known) begin
               rest_x = x;
               rest_y = y;
               position_known = 1'b1;
            end else if (dx > int'(threshold) || dy > int'(threshold)) begin
               rest_x = x;
               rest_y = y;
               timer_active = 1'b1;
               elapsed = '0;
            end
         end
         OP_BUTTON: begin
            if (timer_active) begin
               timer_active = 1'b0;
               elapsed = '0;
               drag_active = 1'b0;
               selected = CT_PRIMARY;
            end
         end
         OP_TICK: begin
            if (timer_active) begin
               target = (dwell_target == 0) ? 16'd1 : dwell_target;
               if (elapsed != '1) elapsed++;
               if (elapsed >= target) begin
                  timer_active = 1'b0;
                  elapsed = '0;
                  if (drag_active) begin
                     drag_active = 1'b0;
                     act[0] = ACT_RELEASE;
                     btn[0] = BTN_LEFT;
                     selected = CT_PRIMARY;
                  end else begin
                     case (selected)
                        CT_PRIMARY: begin
                           act[0] = ACT_CLICK;
                           btn[0] = BTN_LEFT;
                        end
                        CT_MIDDLE: begin
                           act[0] = ACT_CLICK;
                           btn[0] = BTN_MIDDLE;
                           selected = CT_PRIMARY;
                        end
                        CT_SECONDARY: begin
                           act[0] = ACT_CLICK;
                           btn[0] = BTN_RIGHT;
                           selected = CT_PRIMARY;
                        end
                        CT_DOUBLE: begin
                           act[0] = ACT_CLICK;
                           btn[0] = BTN_LEFT;
                           act[1] = ACT_CLICK;
                           btn[1] = BTN_LEFT;
                           n = 2;
                           selected = CT_PRIMARY;
                        end
                        CT_DRAG: begin
                           act[0] = ACT_PRESS;
                           btn[0] = BTN_LEFT;
                           drag_active = 1'b1;
                        end
                        default: ;
                     endcase
                  end
               end
            end
         end
         OP_SET_TYPE: begin
            if (kind <= CT_DRAG) selected = press_kind_type'(kind);
         end
         OP_REARM: position_known = 1'b0;
         default: ;
      endcase
      for (int k = 0; k < n; k++) begin
         r.action = act[k];
         r.button = btn[k];
         r.press_kind = selected;
         r.running = timer_active;
         r.last = (k == n - 1);
         expected_clicks.push_back(r);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         predict_step(req_opcode, req_pos_x, req_pos_y, req_new_click_type);
      if (!reset && csr_valid && csr_ready) begin
         if (csr_index == CSR_MOTION_THRESHOLD) threshold = csr_data[THRESH_BITS-1:0];
         else dwell_target = csr_data;
      end
   end

   always @(posedge clock) begin
      click_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_clicks.size() == 0) begin
            $error("result with no item waiting: action %0d button %0d",
                   rsp_action, rsp_button_number);
            errors++;
         end else begin
            want = expected_clicks.pop_front();
            if (rsp_action !== want.action) begin
               $error("action: expected %0d, got %0d", want.action, rsp_action);
               errors++;
            end
            if (rsp_button_number !== want.button) begin
               $error("button_number: expected %0d, got %0d", want.button,
                      rsp_button_number);
               errors++;
            end
            if (rsp_current_type !== want.press_kind) begin
               $error("current_type: expected %0d, got %0d", want.press_kind,
                      rsp_current_type);
               errors++;
            end
            if (rsp_dwell_running !== want.running) begin
               $error("dwell_running: expected %0d, got %0d", want.running,
                      rsp_dwell_running);
               errors++;
            end
            if (rsp_last_result !== want.last) begin
               $error("last_result: expected %0d, got %0d", want.last, rsp_last_result);
               errors++;
            end
            if (want.action != ACT_NONE) events_seen++;
         end
         stall_left = no_idle ? 0 : $urandom_range(0, 9);
      end
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic logic signed [15:0] clip_coord(input int v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return 16'(v);
   endfunction

   task automatic send_item(input logic [2:0] op, input logic signed [15:0] x,
                            input logic signed [15:0] y, input logic [2:0] kind);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 9);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_pos_x <= x;
      req_pos_y <= y;
      req_new_click_type <= kind;
      do @(posedge clock); while (req_stall !== 1'b0);
      items_sent++;
   endtask

   task automatic send_op(input logic [2:0] op);
      send_item(op, 16'($urandom), 16'($urandom), 3'($urandom));
   endtask

   task automatic send_motion(input int x, input int y);
      send_item(OP_MOTION, clip_coord(x), clip_coord(y), 3'($urandom));
   endtask

   task automatic send_type(input logic [2:0] kind);
      send_item(OP_SET_TYPE, 16'($urandom), 16'($urandom), kind);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_clicks.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(input logic [THRESH_BITS-1:0] thr,
                             input logic [DWELL_BITS-1:0] ticks);
      drain();
      write_csr(CSR_MOTION_THRESHOLD, {6'($urandom), thr});
      write_csr(CSR_DWELL_TICKS, ticks);
      config_sets++;
   endtask

   task automatic test_reset_dwell();
      send_op(OP_TICK);
      send_op(OP_BUTTON);
      send_motion(0, 0);
      send_motion(10, -10);
      send_motion(0, 11);
      no_idle = 1'b1;
      repeat (DWELL_RESET) send_op(OP_TICK);
      no_idle = 1'b0;
   endtask

   task automatic test_click_types();
      set_config(0, 0);
      send_op(OP_REARM);
      send_motion(-32768, 32767);
      send_motion(-32768, 32767);
      send_motion(-32768, 32766);
      send_op(OP_TICK);
      send_type(CT_MIDDLE);
      send_motion(32767, -32768);
      send_op(OP_TICK);
      send_type(CT_SECONDARY);
      send_motion(0, 0);
      send_op(OP_TICK);
      send_type(CT_DOUBLE);
      send_motion(1, 0);
      send_op(OP_TICK);
      send_type(CT_DRAG);
      send_motion(1, 1);
      send_op(OP_TICK);
      send_type(CT_MIDDLE);
      send_motion(0, 1);
      send_op(OP_TICK);
      send_type(CT_DRAG);
      send_motion(0, 0);
      send_op(OP_TICK);
      send_motion(-1, -1);
      send_op(OP_BUTTON);
      for (int k = CT_DRAG + 1; k < 8; k++) send_type(3'(k));
      for (int k = OP_REARM + 1; k < 8; k++) send_op(3'(k));
   endtask

   task automatic test_threshold_edges();
      set_config('1, 1);
      send_op(OP_REARM);
      send_motion(0, 0);
      send_motion(1023, -1023);
      send_op(OP_TICK);
      send_motion(1024, 0);
      send_op(OP_TICK);
      send_motion(32767, -32768);
      send_motion(-32768, 32767);
      send_op(OP_TICK);
   endtask

   task automatic run_random(input int count);
      int          pick;
      int          thr;
      int          off;
      logic [2:0]  op;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
         pick = $urandom_range(0, 99);
         thr = int'(threshold);
         if (pick < 15) begin
            off = int'($urandom_range(0, 2 * thr)) - thr;
            send_motion(int'(rest_x) + off, int'(rest_y) + int'($urandom_range(0, 2 * thr)) - thr);
         end else if (pick < 30) begin
            off = thr + 1 + int'($urandom_range(0, 50));
            if ($urandom_range(0, 1)) off = -off;
            if ($urandom_range(0, 1)) send_motion(int'(rest_x) + off, int'(rest_y));
            else send_motion(int'(rest_x), int'(rest_y) + off);
         end else if (pick < 34) begin
            send_item(OP_MOTION, 16'($urandom), 16'($urandom), 3'($urandom));
         end else if (pick < 70) begin
            send_op(OP_TICK);
         end else if (pick < 77) begin
            send_op(OP_BUTTON);
         end else if (pick < 86) begin
            send_type(3'($urandom_range(CT_PRIMARY, CT_DRAG)));
         end else if (pick < 89) begin
            send_type(3'($urandom));
         end else if (pick < 95) begin
            send_op(OP_REARM);
         end else begin
            op = OP_REARM + 3'($urandom_range(1, 3));
            send_op(op);
         end
      end
      no_idle = 1'b0;
   endtask

   task automatic test_random();
      set_config(10'($urandom), 16'($urandom_range(1, 6)));
      run_random(60);
      set_config(0, 1);
      run_random(60);
      set_config('1, 4);
      run_random(60);
      set_config(10'($urandom_range(0, 40)), 0);
      run_random(60);
      set_config(10'($urandom), 16'($urandom_range(1, 8)));
      run_random(60);
      set_config(10'($urandom_range(0, 100)), 2);
      run_random(60);
   endtask

   task automatic test_long_dwell();
      set_config(10'($urandom), '1);
      send_op(OP_REARM);
      send_motion(0, 0);
      send_motion(32767, -32768);
      send_type(CT_DOUBLE);
      no_idle = 1'b1;
      repeat (200) send_op(OP_TICK);
      no_idle = 1'b0;
      send_op(OP_BUTTON);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = '0;
      req_pos_x = '0;
      req_pos_y = '0;
      req_new_click_type = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      test_reset_dwell();
      test_click_types();
      test_threshold_edges();
      test_random();
      test_long_dwell();
      drain();

      $display("Sent %0d items over %0d register settings; checked %0d results.",
               items_sent, config_sets, results_seen);
      $display("Results carrying a button event: %0d.", events_seen);
      if (errors == 0) begin
         $display("** dwell_click_controller: PASSED **");
      end else begin
         $display("** dwell_click_controller: FAILED **");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("** dwell_click_controller: FAILED **");
      $finish;
   end

endmodule

FILE: dwell_click_controller.f
rtl/core/dcc_pkg.sv
rtl/core/dcc_engine.sv
rtl/core/dwell_click_controller.sv
sim/testbench.sv
